/* src/frsc_pkg.sv */
// Package for the frame ring select/consume block.
// Holds request codes, status codes, controller states and command/status structs.
package frsc_pkg;

  typedef enum logic [2:0] {
    FN_PUSH    = 3'd0,
    FN_POP     = 3'd1,
    FN_PEEK    = 3'd2,
    FN_FIND    = 3'd3,
    FN_CONSUME = 3'd4,
    FN_NEAREST = 3'd5,
    FN_CLEAR   = 3'd6,
    FN_NONE    = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_DROP,
    S_CLEAR,
    S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture request, reset scan state
    logic scan_step;  // examine slot at scan offset
    logic push;       // write request into the ring
    logic pop_one;    // wipe oldest slot and advance
    logic clr_step;   // wipe slot at clear index
    logic clr_done;   // reset pointers after clear sweep
    logic latch_pick; // latch the selected slot into the result
    logic latch_head; // latch the oldest slot into the result
    logic set_ok;     // result succeeded
    logic post_fail;  // record the status of a failed request
    status_t status;  // result status
  } frsc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;  // current scan offset is the last held slot
    logic exact_hit;  // current scan slot matches exactly (valid)
    logic have_pick;  // a candidate was selected
    logic pick_valid; // selected slot (consume) is valid
    logic drop_last;  // the drop reaching the picked slot
    logic clr_last;
  } frsc_sts_t;

endpackage

/* src/frsc_datapath.sv */
// Datapath of the frame ring: slot storage, pointers, scan and selection registers.
// Depends on frsc_pkg.
module frsc_datapath import frsc_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  frsc_cmd_t                    cmd,
  output frsc_sts_t                    sts,
  input  logic [2:0]                   in_func,
  input  logic [30:0]                  in_frame_number,
  input  logic [31:0]                  in_frame_handle,
  input  logic                         in_frame_valid,
  output logic                         res_ok,
  output logic [1:0]                   res_status,
  output logic [30:0]                  res_number,
  output logic [31:0]                  res_handle,
  output logic                         res_valid,
  output logic [$clog2(CAPACITY+1)-1:0] res_occ
);
  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [30:0]   num_r [CAPACITY];
  logic [31:0]   hdl_r [CAPACITY];
  logic [CAPACITY-1:0] vld_r;
  logic [PW-1:0] rd_r, wr_r;
  logic [CW-1:0] cnt_r;

  logic [2:0]    func_r;
  logic [30:0]   tgt_r;
  logic [31:0]   hin_r;
  logic          vin_r;
  logic [CW-1:0] off_r;     // scan offset, also drop counter
  logic [PW-1:0] clr_r;
  logic          have_r, exact_r;
  logic [CW-1:0] pick_r;
  logic [30:0]   best_r;    // distance (nearest) or number below (consume)

  function automatic logic [PW-1:0] wrap(input logic [PW:0] v);
    logic [PW:0] c;
    c = (PW+1)'(CAPACITY);
    return (v >= c) ? PW'(v - c) : PW'(v);
  endfunction

  logic [PW-1:0] scan_idx, pick_idx;
  logic [30:0]   s_num, gap;
  logic          s_vld;
  assign scan_idx = wrap({1'b0, rd_r} + (PW+1)'(off_r));
  assign pick_idx = wrap({1'b0, rd_r} + (PW+1)'(pick_r));
  assign s_num = num_r[scan_idx];
  assign s_vld = vld_r[scan_idx];
  assign gap   = (s_num >= tgt_r) ? s_num - tgt_r : tgt_r - s_num;

  assign sts.full       = (cnt_r == CW'(CAPACITY));
  assign sts.empty      = (cnt_r == '0);
  assign sts.scan_last  = (off_r + CW'(1) >= cnt_r);
  assign sts.exact_hit  = s_vld && (s_num == tgt_r);
  assign sts.have_pick  = have_r;
  assign sts.pick_valid = vld_r[pick_idx];
  assign sts.drop_last  = (off_r >= pick_r) || (cnt_r == CW'(1));
  assign sts.clr_last   = (clr_r == PW'(CAPACITY - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      tgt_r  <= in_frame_number;
      hin_r  <= in_frame_handle;
      vin_r  <= in_frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
      off_r <= '0;
      clr_r <= '0;
      have_r <= 1'b0;
      exact_r <= 1'b0;
      pick_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        num_r[i] <= '0;
        hdl_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        off_r   <= '0;
        clr_r   <= '0;
        have_r  <= 1'b0;
        exact_r <= 1'b0;
        pick_r  <= '0;
      end
      if (cmd.scan_step) begin
        off_r <= off_r + CW'(1);
        if (!exact_r && s_vld) begin
          if (s_num == tgt_r) begin
            exact_r <= 1'b1;
            have_r  <= 1'b1;
            pick_r  <= off_r;
          end else if (func_r == FN_NEAREST) begin
            if (!have_r || gap < best_r) begin
              have_r <= 1'b1;
              best_r <= gap;
              pick_r <= off_r;
            end
          end else if (func_r == FN_CONSUME) begin
            if (s_num < tgt_r && (!have_r || s_num > best_r)) begin
              have_r <= 1'b1;
              best_r <= s_num;
              pick_r <= off_r;
            end
          end
        end
      end
      // The drop counter restarts from the oldest slot once the pick is taken.
      if (cmd.latch_pick) off_r <= '0;
      if (cmd.push) begin
        num_r[wr_r] <= tgt_r;
        hdl_r[wr_r] <= hin_r;
        vld_r[wr_r] <= vin_r;
        wr_r  <= wrap({1'b0, wr_r} + (PW+1)'(1));
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.pop_one) begin
        num_r[rd_r] <= '0;
        hdl_r[rd_r] <= '0;
        vld_r[rd_r] <= 1'b0;
        rd_r  <= wrap({1'b0, rd_r} + (PW+1)'(1));
        cnt_r <= cnt_r - CW'(1);
        off_r <= off_r + CW'(1);
      end
      if (cmd.clr_step) begin
        num_r[clr_r] <= '0;
        hdl_r[clr_r] <= '0;
        vld_r[clr_r] <= 1'b0;
        clr_r <= clr_r + PW'(1);
      end
      if (cmd.clr_done) begin
        rd_r  <= '0;
        wr_r  <= '0;
        cnt_r <= '0;
      end
    end
  end

  // Result register; occupancy is read live once the request has settled.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_number <= '0;
      res_handle <= '0;
      res_valid  <= 1'b0;
    end else if (cmd.latch_pick) begin
      res_number <= num_r[pick_idx];
      res_handle <= hdl_r[pick_idx];
      res_valid  <= vld_r[pick_idx];
    end else if (cmd.latch_head) begin
      res_number <= num_r[rd_r];
      res_handle <= hdl_r[rd_r];
      res_valid  <= vld_r[rd_r];
    end
    if (cmd.set_ok || cmd.post_fail || cmd.latch_pick || cmd.latch_head || cmd.load) begin
      res_ok     <= cmd.set_ok;
      res_status <= cmd.status;
    end
  end
  assign res_occ = cnt_r;

  // Occupancy never exceeds the ring size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(CAPACITY))
    else $error("held count above capacity");
  // A push is never issued into a full ring.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full) else $error("push into full ring");
  // A pop is never issued on an empty ring.
  a_pop_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_one |-> !sts.empty) else $error("pop from empty ring");
endmodule

/* src/frsc_ctrl.sv */
// Controller state machine of the frame ring: sequences scans, drops and clears.
// Depends on frsc_pkg.
module frsc_ctrl import frsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [2:0] in_func,
  output logic      out_valid_q,
  input  logic      out_ready,
  output frsc_cmd_t cmd,
  input  frsc_sts_t sts
);
  state_t state_r, state_nxt;
  func_t  func_r;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      func_r  <= FN_NONE;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (in_valid && in_ready) func_r <= func_t'(in_func);
    end
  end

  assign in_ready    = (state_r == S_IDLE) && !ov_r;
  assign out_valid_q = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.status = ST_NOTFOUND;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // First cycle after load decides the short requests.
        unique case (func_r)
          FN_CLEAR: state_nxt = S_CLEAR;
          FN_PUSH: begin
            if (sts.full) cmd.status = ST_FULL;
            else begin
              cmd.push = 1'b1; cmd.status = ST_DONE; cmd.set_ok = 1'b1;
            end
            cmd.load = 1'b0;
            state_nxt = S_OUT;
          end
          FN_NONE: begin
            cmd.status = ST_NOTFOUND; cmd.set_ok = 1'b0;
            state_nxt = S_OUT;
          end
          default: begin
            if (sts.empty) begin
              cmd.status = ST_EMPTY;
              state_nxt  = S_OUT;
            end else if (func_r == FN_POP || func_r == FN_PEEK) begin
              cmd.latch_head = 1'b1; cmd.set_ok = 1'b1; cmd.status = ST_DONE;
              cmd.pop_one    = (func_r == FN_POP);
              state_nxt      = S_OUT;
            end else begin
              cmd.scan_step = 1'b1;
              if (sts.scan_last || sts.exact_hit) state_nxt = S_PICK;
            end
          end
        endcase
        // A full or empty ring or the unused code fails here, so its status has to be recorded.
        if (state_nxt == S_OUT && !cmd.set_ok) cmd.post_fail = 1'b1;
      end
      S_PICK: begin
        if (func_r == FN_CONSUME) begin
          if (sts.pick_valid) begin
            cmd.latch_pick = 1'b1; cmd.set_ok = 1'b1; cmd.status = ST_DONE;
            state_nxt = S_DROP;
          end else begin
            cmd.status = ST_NOTFOUND;
            state_nxt  = S_OUT;
          end
        end else if (sts.have_pick) begin
          cmd.latch_pick = 1'b1; cmd.set_ok = 1'b1; cmd.status = ST_DONE;
          state_nxt = S_OUT;
        end else begin
          cmd.status = ST_NOTFOUND;
          state_nxt  = S_OUT;
        end
      end
      S_DROP: begin
        cmd.pop_one = 1'b1;
        if (sts.drop_last) state_nxt = S_OUT;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.clr_done = 1'b1;
          cmd.set_ok   = 1'b1;
          cmd.status   = ST_DONE;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // No new request is taken while a result waits.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !in_ready) else $error("request taken with result pending");
  // A result appears only when leaving the output state.
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == S_OUT) else $error("stray result");
  // Drops run only for consume requests.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DROP |-> func_r == FN_CONSUME) else $error("drop outside consume");
endmodule

/* src/frame_ring_select_consume.sv */
// Top level of the frame ring with tagged search.
// Depends on frsc_pkg, frsc_ctrl and frsc_datapath.
//
// A request transaction on the in_ channel carries a function code, a frame
// number, a handle and a valid mark. Each request gives exactly one result
// transaction on the out_ channel with ok, status, the returned slot and the
// occupancy after the request.
// Push, pop, peek, the unused code and requests that fail on a full or empty
// ring raise out_valid after the scan state and the output state. Find and
// nearest walk the held slots one per cycle up to the first exact match, then
// pass through the pick state. Consume then drops the held slots from the
// oldest up to the picked one, one per cycle, and clear sweeps all CAPACITY
// slots one per cycle. One request is in flight at a time, and in_ready
// returns the cycle after the result transaction is taken.
// After reset the ring is empty and all slots read as zero. While a result
// waits for out_ready the block holds it stable and takes no new request.
module frame_ring_select_consume import frsc_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [30:0] in_frame_number,
  input  logic [31:0] in_frame_handle,
  input  logic        in_frame_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [1:0]  out_status,
  output logic [30:0] out_number,
  output logic [31:0] out_handle,
  output logic        out_valid_bit,
  output logic [3:0]  out_occupancy
);
  localparam int CW = $clog2(CAPACITY + 1);

  frsc_cmd_t     cmd;
  frsc_sts_t     sts;
  logic [CW-1:0] occ;

  frsc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_func,
    .out_valid_q(out_valid), .out_ready, .cmd, .sts
  );

  frsc_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_func, .in_frame_number, .in_frame_handle,
    .in_frame_valid, .res_ok(out_ok), .res_status(out_status),
    .res_number(out_number), .res_handle(out_handle), .res_valid(out_valid_bit),
    .res_occ(occ)
  );

  // The model reports the low four bits of the held count.
  if (CW >= 4) begin : g_occ_wide
    assign out_occupancy = occ[3:0];
  end else begin : g_occ_narrow
    assign out_occupancy = 4'(occ);
  end
endmodule
